// ----- rtl/core/saet_pkg.sv -----
// Package for the swept box entry time block: word types and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
package saet_pkg;

  localparam int CoordBits    = 24;
  localparam int TimeFracBits = 16;
  localparam int NumAxes      = 3;

  typedef struct packed {
    logic signed [CoordBits-1:0] offset_x;
    logic signed [CoordBits-1:0] offset_y;
    logic signed [CoordBits-1:0] offset_z;
    logic [CoordBits-2:0]        mover_size_x;
    logic [CoordBits-2:0]        mover_size_y;
    logic [CoordBits-2:0]        mover_size_z;
    logic [CoordBits-2:0]        target_size_x;
    logic [CoordBits-2:0]        target_size_y;
    logic [CoordBits-2:0]        target_size_z;
    logic signed [CoordBits-1:0] vel_x;
    logic signed [CoordBits-1:0] vel_y;
    logic signed [CoordBits-1:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic [TimeFracBits:0] touch_time;
    logic                  hit;
  } out_word_t;

endpackage

// ----- rtl/core/saet_divstage.sv -----
// One restoring-division step shared by the pipelined quotient lanes.
// Depends on nothing; widths come from parameters.
`timescale 1ns / 1ps
module saet_divstage #(
  parameter int NW = 27,
  parameter int DW = 24,
  parameter int QW = 18
) (
  input  logic [NW-1:0] rem_in,
  input  logic [DW-1:0] den,
  input  logic [QW-1:0] q_in,
  output logic [NW-1:0] rem_out,
  output logic [QW-1:0] q_out
);
  logic [NW:0] sh;
  always_comb begin
    sh = {rem_in, 1'b0};
    if (sh >= {{(NW+1-DW){1'b0}}, den}) begin
      rem_out = NW'(sh - {{(NW+1-DW){1'b0}}, den});
      q_out   = {q_in[QW-2:0], 1'b1};
    end else begin
      rem_out = sh[NW-1:0];
      q_out   = {q_in[QW-2:0], 1'b0};
    end
  end
endmodule

// ----- rtl/core/saet_lane.sv -----
// Per-axis lane: picks entry and exit distances, then two pipelined dividers give
// signed Q2.F times saturated to [-2, 2]. Uses saet_divstage.
`timescale 1ns / 1ps
module saet_lane #(
  parameter int CB   = 24,
  parameter int TF   = 16,
  parameter bit DOWN = 1'b0
) (
  input  logic                 clk,
  input  logic                 advance,
  input  logic signed [CB-1:0] off,
  input  logic [CB-2:0]        msz,
  input  logic [CB-2:0]        tsz,
  input  logic signed [CB-1:0] vel,
  output logic signed [TF+2:0] t_in,
  output logic signed [TF+2:0] t_out
);
  // distances need CB+1 bits signed; magnitude fits in CB+1 unsigned bits
  localparam int DW = CB + 1;
  localparam int NW = DW + 1;   // remainder < 2*den
  localparam int QW = TF + 2;   // quotient integer part 0..1 plus fraction
  localparam int ST = TF + 1;   // 1 integer step plus TF fraction steps
  localparam logic [QW-1:0] SAT = QW'(2) << TF;

  logic signed [DW-1:0] din, dout, offe, me, te;
  always_comb begin
    offe = DW'(off);
    me   = signed'({2'b00, msz});
    te   = signed'({2'b00, tsz});
    if (!DOWN) begin
      din  = (vel > 0) ? offe - me : offe + te;
      dout = (vel > 0) ? offe + te : offe - me;
    end else begin
      din  = (vel > 0) ? offe - te : offe + me;
      dout = (vel > 0) ? offe + me : offe - te;
    end
  end

  // stage 0 register: magnitudes, signs, flags
  logic [DW-1:0] n0 [2];
  logic [DW-1:0] m0;
  logic [1:0]    neg0, sat0;
  logic          zero0;
  logic [DW-1:0] na, nb, mv;
  always_comb begin
    na = din[DW-1] ? DW'(-din) : DW'(din);
    nb = dout[DW-1] ? DW'(-dout) : DW'(dout);
    mv = vel[CB-1] ? DW'(-DW'(vel)) : DW'(vel);
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      n0[0] <= na;
      n0[1] <= nb;
      m0    <= mv;
      neg0  <= {dout[DW-1] ^ vel[CB-1], din[DW-1] ^ vel[CB-1]};
      sat0  <= {({1'b0, nb} >= {mv, 1'b0}), ({1'b0, na} >= {mv, 1'b0})};
      zero0 <= (vel == '0);
    end
  end

  // division pipe: ST stages, numerator bits fed MSB first from a shifted copy
  logic [NW-1:0] rem [2][ST+1];
  logic [QW-1:0] q   [2][ST+1];
  logic [DW-1:0] den [ST+1];
  logic [1:0]    negp [ST+1];
  logic [1:0]    satp [ST+1];
  logic          zp   [ST+1];

  // since n < 2m the integer part is 0 or 1: start with remainder n >> 1
  // and bring in bit 0 as the first step, then zeros.
  logic [NW-1:0] rem_s [2][ST];
  logic [QW-1:0] q_s   [2][ST];
  always_comb begin
    rem[0][0] = NW'(n0[0] >> 1);
    rem[1][0] = NW'(n0[1] >> 1);
    q[0][0]   = '0;
    q[1][0]   = '0;
    den[0]    = m0;
    negp[0]   = neg0;
    satp[0]   = sat0;
    zp[0]     = zero0;
  end

  logic [1:0] lsb0;
  assign lsb0 = {n0[1][0], n0[0][0]};

  for (genvar s = 0; s < ST; s++) begin : g_st
    for (genvar k = 0; k < 2; k++) begin : g_k
      if (s == 0) begin : g_first
        // first step brings in the numerator LSB
        logic [NW:0] sh;
        always_comb begin
          sh = {rem[k][0], lsb0[k]};
          if (sh >= {{(NW+1-DW){1'b0}}, den[0]}) begin
            rem_s[k][s] = NW'(sh - {{(NW+1-DW){1'b0}}, den[0]});
            q_s[k][s]   = QW'(1);
          end else begin
            rem_s[k][s] = sh[NW-1:0];
            q_s[k][s]   = '0;
          end
        end
      end else begin : g_rest
        // later steps shift in zeros
        saet_divstage #(.NW(NW), .DW(DW), .QW(QW)) u_st (
          .rem_in (rem[k][s]),
          .den    (den[s]),
          .q_in   (q[k][s]),
          .rem_out(rem_s[k][s]),
          .q_out  (q_s[k][s])
        );
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          rem[k][s+1] <= rem_s[k][s];
          q[k][s+1]   <= q_s[k][s];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        den[s+1]  <= den[s];
        negp[s+1] <= negp[s];
        satp[s+1] <= satp[s];
        zp[s+1]   <= zp[s];
      end
    end
  end

  logic [QW-1:0] mag [2];
  always_comb begin
    for (int k = 0; k < 2; k++)
      mag[k] = satp[ST][k] ? SAT : q[k][ST];
    if (zp[ST]) begin
      t_in  = -signed'((TF+3)'(SAT));
      t_out = signed'((TF+3)'(SAT));
    end else begin
      t_in  = negp[ST][0] ? -signed'((TF+3)'(mag[0])) : signed'((TF+3)'(mag[0]));
      t_out = negp[ST][1] ? -signed'((TF+3)'(mag[1])) : signed'((TF+3)'(mag[1]));
    end
  end
endmodule

// ----- rtl/core/saet_merge.sv -----
// Merge stage: max entry, min exit, hit decision over three lanes.
// No package dependency; widths by parameter.
`timescale 1ns / 1ps
module saet_merge #(
  parameter int TF = 16
) (
  input  logic signed [TF+2:0] te [3],
  input  logic signed [TF+2:0] tx [3],
  output logic [TF:0]          touch_time,
  output logic                 hit
);
  localparam logic signed [TF+2:0] ONE = (TF+3)'(1) <<< TF;
  logic signed [TF+2:0] en, ex;
  logic miss;
  always_comb begin
    en = te[0];
    ex = tx[0];
    for (int k = 1; k < 3; k++) begin
      if (te[k] > en) en = te[k];
      if (tx[k] < ex) ex = tx[k];
    end
    miss = (en > ex) || (te[0][TF+2] && te[1][TF+2] && te[2][TF+2]) ||
           (te[0] > ONE) || (te[1] > ONE) || (te[2] > ONE);
    hit        = !miss;
    touch_time = miss ? ONE[TF:0] : en[TF:0];
  end
endmodule

// ----- rtl/core/swept_aabb_entry_time_3d.sv -----
// Swept 3D box entry time: three axis lanes with pipelined dividers, then a merge.
// Throughput one word per cycle while the output register is empty or drained;
// the divider pipelines in each lane set the depth of the pipe.
// Output register holds a finished word while stalled; the pipe advances only when
// its last stage is free. rst clears the valid bits; data registers are not reset.
// Uses saet_pkg, saet_lane, saet_merge.
`timescale 1ns / 1ps
module swept_aabb_entry_time_3d (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  saet_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output saet_pkg::out_word_t  out_word
);
  localparam int CB  = saet_pkg::CoordBits;
  localparam int TF  = saet_pkg::TimeFracBits;
  localparam int LAT = TF + 2;  // lane: entry reg + TF+1 divide steps

  // valid bits follow the words through the lane pipe
  logic [LAT-1:0] vpipe;
  logic           advance;
  // pipe moves when the output register is empty or being drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (advance) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  logic signed [TF+2:0] te [3];
  logic signed [TF+2:0] tx [3];

  saet_lane #(.CB(CB), .TF(TF), .DOWN(1'b0)) u_lane_x (
    .clk(clk), .advance(advance), .off(in_word.offset_x), .msz(in_word.mover_size_x),
    .tsz(in_word.target_size_x), .vel(in_word.vel_x), .t_in(te[0]), .t_out(tx[0]));
  saet_lane #(.CB(CB), .TF(TF), .DOWN(1'b1)) u_lane_y (
    .clk(clk), .advance(advance), .off(in_word.offset_y), .msz(in_word.mover_size_y),
    .tsz(in_word.target_size_y), .vel(in_word.vel_y), .t_in(te[1]), .t_out(tx[1]));
  saet_lane #(.CB(CB), .TF(TF), .DOWN(1'b1)) u_lane_z (
    .clk(clk), .advance(advance), .off(in_word.offset_z), .msz(in_word.mover_size_z),
    .tsz(in_word.target_size_z), .vel(in_word.vel_z), .t_in(te[2]), .t_out(tx[2]));

  logic [TF:0] et;
  logic        h;
  saet_merge #(.TF(TF)) u_merge (.te(te), .tx(tx), .touch_time(et), .hit(h));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vpipe[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      out_word.touch_time <= et;
      out_word.hit        <= h;
    end
  end
endmodule

// ----- rtl/core/saet_checker.sv -----
// Port-level checker for swept_aabb_entry_time_3d, bound to the top level.
// Uses saet_pkg for the word types.
`timescale 1ns / 1ps
module saet_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input saet_pkg::out_word_t out_word
);
  localparam logic [saet_pkg::TimeFracBits:0] ONE =
    (saet_pkg::TimeFracBits+1)'(1) << saet_pkg::TimeFracBits;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.hit |-> out_word.touch_time == ONE)
    else $error("miss word without 1.0 time");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.touch_time <= ONE)
    else $error("entry time above 1.0");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");
endmodule

bind swept_aabb_entry_time_3d saet_checker u_saet_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word));
